### rtl/core/mcdt_pkg.sv
// shared constants and types for the midi clock divider and tempo meter
package mcdt_pkg;

    localparam int TIME_W      = 32;
    localparam int COUNT_W     = 32;
    localparam int TEMPO_W     = 8;
    localparam int PHASE_W     = 5;
    localparam int CLOCKS_PER_QUARTER = 24;

    // tempo divide: numerator and divisor both stay below 2^28
    localparam int DIV_W       = 28;
    localparam int DIV_STEP_W  = 5;

    localparam logic [TIME_W-1:0]  TWO_MINUTES_US  = TIME_W'(120000000);
    localparam logic [TEMPO_W-1:0] START_TEMPO     = TEMPO_W'(90);
    localparam logic [TEMPO_W-1:0] MAX_TEMPO_RESET = TEMPO_W'(240);

    // operation codes
    localparam logic OP_CLOCK = 1'b0;
    localparam logic OP_START = 1'b1;

    // divider handshake toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

### rtl/core/mcdt_midi_if.sv
// input channel: midi clock or start transaction with timestamp
interface mcdt_midi_if;
    import mcdt_pkg::*;

    logic                valid;
    logic                ready;
    logic                operation;
    logic [TIME_W-1:0]   timestamp_us;

    modport source (output valid, output operation, output timestamp_us, input ready);
    modport sink   (input valid, input operation, input timestamp_us, output ready);
endinterface

### rtl/core/mcdt_result_if.sv
// output channel: note counters, toggles and tempo per transaction
interface mcdt_result_if;
    import mcdt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 forward_clock;
    logic [COUNT_W-1:0]   thirtysecond_count;
    logic [COUNT_W-1:0]   sixteenth_count;
    logic [COUNT_W-1:0]   eighth_count;
    logic [COUNT_W-1:0]   quarter_count;
    logic                 eighth_toggle;
    logic                 quarter_toggle;
    logic [TEMPO_W-1:0]   tempo_bpm;
    logic                 tempo_updated;

    modport source (
        output valid, output forward_clock, output thirtysecond_count,
        output sixteenth_count, output eighth_count, output quarter_count,
        output eighth_toggle, output quarter_toggle, output tempo_bpm,
        output tempo_updated, input ready
    );
    modport sink (
        input valid, input forward_clock, input thirtysecond_count,
        input sixteenth_count, input eighth_count, input quarter_count,
        input eighth_toggle, input quarter_toggle, input tempo_bpm,
        input tempo_updated, output ready
    );
endinterface

### rtl/core/mcdt_div.sv
// restoring divider, one quotient bit per cycle
module mcdt_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [mcdt_pkg::DIV_W-1:0]  dividend,
    input  logic [mcdt_pkg::DIV_W-1:0]  divisor,
    output mcdt_pkg::div_status_t       status,
    output logic [mcdt_pkg::DIV_W-1:0]  quotient
);
    import mcdt_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_STEP_W-1:0]  step_reg, step_next;
    logic [DIV_W-1:0]       quo_reg, quo_next;
    logic [DIV_W-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]       dsr_reg, dsr_next;
    logic [DIV_W:0]         trial;
    logic [DIV_W:0]         diff;

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_W])
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == DIV_STEP_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

### rtl/core/midi_clock_divider_tempo.sv
// top level: midi clock phase, note counters and tempo measurement
//
//   channel   | dir | transaction
//   ----------+-----+-------------------------------------------------
//   midi      | in  | operation (clock / start), timestamp_us
//   result    | out | forward flag, four note counts, toggles, tempo
//   cfg_we    | in  | max_tempo write, one register, no read-back
//
// a clock that ends a quarter note with an interval of 1 to 120e6 us passes through the
// 28-step divider in ST_DIV before ST_PUSH; other clocks and starts go to ST_PUSH directly.
// midi.ready is high only while the sequencer is idle; a finished result
// waits in the output register while the next transaction is accepted.
// reset (rst_n, async low) clears counters, toggles, phase and start time,
// sets tempo to 90 and max_tempo to 240.
module midi_clock_divider_tempo (
    input  logic                          clk,
    input  logic                          rst_n,
    mcdt_midi_if.sink                     midi,
    mcdt_result_if.source                 result,
    input  logic                          cfg_we,
    input  logic [mcdt_pkg::TEMPO_W-1:0]  cfg_wdata
);
    import mcdt_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH
    } state_t;

    state_t                 state_reg, state_next;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [COUNT_W-1:0]     c32_reg, c32_next;
    logic [COUNT_W-1:0]     c16_reg, c16_next;
    logic [COUNT_W-1:0]     c8_reg, c8_next;
    logic [COUNT_W-1:0]     c4_reg, c4_next;
    logic                   eflag_reg, eflag_next;
    logic                   qflag_reg, qflag_next;
    logic [TIME_W-1:0]      qstart_reg, qstart_next;
    logic [TEMPO_W-1:0]     tempo_reg, tempo_next;
    logic [TEMPO_W-1:0]     max_tempo_reg, max_tempo_next;
    logic                   fwd_reg, fwd_next;
    logic                   upd_reg, upd_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_fwd_reg, out_fwd_next;
    logic [COUNT_W-1:0]     out_c32_reg, out_c32_next;
    logic [COUNT_W-1:0]     out_c16_reg, out_c16_next;
    logic [COUNT_W-1:0]     out_c8_reg, out_c8_next;
    logic [COUNT_W-1:0]     out_c4_reg, out_c4_next;
    logic                   out_eflag_reg, out_eflag_next;
    logic                   out_qflag_reg, out_qflag_next;
    logic [TEMPO_W-1:0]     out_tempo_reg, out_tempo_next;
    logic                   out_upd_reg, out_upd_next;

    logic                   accept;
    logic [PHASE_W-1:0]     phase_inc;
    logic [TIME_W-1:0]      dt;
    logic                   div_start;
    logic [DIV_W-1:0]       div_dividend;
    logic [DIV_W-1:0]       div_divisor;
    div_status_t            div_status;
    logic [DIV_W-1:0]       div_quotient;

    // phase points where each note length ends
    function automatic logic hit_third(input logic [PHASE_W-1:0] p);
        logic r;
        case (p)
            PHASE_W'(3), PHASE_W'(6), PHASE_W'(9), PHASE_W'(12),
            PHASE_W'(15), PHASE_W'(18), PHASE_W'(21), PHASE_W'(24): r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic hit_sixth(input logic [PHASE_W-1:0] p);
        logic r;
        case (p)
            PHASE_W'(6), PHASE_W'(12), PHASE_W'(18), PHASE_W'(24): r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic hit_twelfth(input logic [PHASE_W-1:0] p);
        logic r;
        case (p)
            PHASE_W'(12), PHASE_W'(24): r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    assign midi.ready = (state_reg == ST_IDLE);
    assign accept     = midi.valid && midi.ready;
    assign phase_inc  = phase_reg + 1'b1;
    assign dt         = midi.timestamp_us - qstart_reg;

    // rounded tempo: (120e6 + dt) / (2 dt), dt no more than 120e6 here
    assign div_dividend = DIV_W'(TWO_MINUTES_US) + dt[DIV_W-1:0];
    assign div_divisor  = {dt[DIV_W-2:0], 1'b0};

    mcdt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // sequencer and state update
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        c32_next       = c32_reg;
        c16_next       = c16_reg;
        c8_next        = c8_reg;
        c4_next        = c4_reg;
        eflag_next     = eflag_reg;
        qflag_next     = qflag_reg;
        qstart_next    = qstart_reg;
        tempo_next     = tempo_reg;
        max_tempo_next = cfg_we ? cfg_wdata : max_tempo_reg;
        fwd_next       = fwd_reg;
        upd_next       = upd_reg;
        div_start      = 1'b0;

        out_valid_next = out_valid_reg && !result.ready;
        out_fwd_next   = out_fwd_reg;
        out_c32_next   = out_c32_reg;
        out_c16_next   = out_c16_reg;
        out_c8_next    = out_c8_reg;
        out_c4_next    = out_c4_reg;
        out_eflag_next = out_eflag_reg;
        out_qflag_next = out_qflag_reg;
        out_tempo_next = out_tempo_reg;
        out_upd_next   = out_upd_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PUSH;
                    if (midi.operation == OP_START)
                    begin
                        phase_next  = '0;
                        c32_next    = '0;
                        c16_next    = '0;
                        c8_next     = '0;
                        c4_next     = '0;
                        eflag_next  = 1'b0;
                        qflag_next  = 1'b0;
                        qstart_next = midi.timestamp_us;
                        tempo_next  = START_TEMPO;
                        fwd_next    = 1'b0;
                        upd_next    = 1'b0;
                    end
                    else
                    begin
                        fwd_next   = phase_reg[0];
                        upd_next   = 1'b0;
                        phase_next = phase_inc;
                        if (hit_third(phase_inc))
                            c32_next = c32_reg + 1'b1;
                        if (hit_sixth(phase_inc))
                            c16_next = c16_reg + 1'b1;
                        if (hit_twelfth(phase_inc))
                        begin
                            c8_next    = c8_reg + 1'b1;
                            eflag_next = ~eflag_reg;
                        end
                        // quarter note ends: wrap and measure tempo
                        if (phase_inc == PHASE_W'(CLOCKS_PER_QUARTER))
                        begin
                            phase_next  = '0;
                            qflag_next  = ~qflag_reg;
                            c4_next     = c4_reg + 1'b1;
                            qstart_next = midi.timestamp_us;
                            upd_next    = 1'b1;
                            if (dt == '0)
                                tempo_next = max_tempo_reg;
                            else if (dt > TWO_MINUTES_US)
                                tempo_next = '0;
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                    end
                end
            end

            ST_DIV:
            begin
                if (div_status.done)
                begin
                    if (div_quotient > DIV_W'(max_tempo_reg))
                        tempo_next = max_tempo_reg;
                    else
                        tempo_next = div_quotient[TEMPO_W-1:0];
                    state_next = ST_PUSH;
                end
            end

            ST_PUSH:
            begin
                // load the output register once it is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_fwd_next   = fwd_reg;
                    out_c32_next   = c32_reg;
                    out_c16_next   = c16_reg;
                    out_c8_next    = c8_reg;
                    out_c4_next    = c4_reg;
                    out_eflag_next = eflag_reg;
                    out_qflag_next = qflag_reg;
                    out_tempo_next = tempo_reg;
                    out_upd_next   = upd_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            c32_reg       <= '0;
            c16_reg       <= '0;
            c8_reg        <= '0;
            c4_reg        <= '0;
            eflag_reg     <= 1'b0;
            qflag_reg     <= 1'b0;
            qstart_reg    <= '0;
            tempo_reg     <= START_TEMPO;
            max_tempo_reg <= MAX_TEMPO_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            c32_reg       <= c32_next;
            c16_reg       <= c16_next;
            c8_reg        <= c8_next;
            c4_reg        <= c4_next;
            eflag_reg     <= eflag_next;
            qflag_reg     <= qflag_next;
            qstart_reg    <= qstart_next;
            tempo_reg     <= tempo_next;
            max_tempo_reg <= max_tempo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload and per-transaction flags
    always_ff @(posedge clk)
    begin
        fwd_reg       <= fwd_next;
        upd_reg       <= upd_next;
        out_fwd_reg   <= out_fwd_next;
        out_c32_reg   <= out_c32_next;
        out_c16_reg   <= out_c16_next;
        out_c8_reg    <= out_c8_next;
        out_c4_reg    <= out_c4_next;
        out_eflag_reg <= out_eflag_next;
        out_qflag_reg <= out_qflag_next;
        out_tempo_reg <= out_tempo_next;
        out_upd_reg   <= out_upd_next;
    end

    assign result.valid              = out_valid_reg;
    assign result.forward_clock      = out_fwd_reg;
    assign result.thirtysecond_count = out_c32_reg;
    assign result.sixteenth_count    = out_c16_reg;
    assign result.eighth_count       = out_c8_reg;
    assign result.quarter_count      = out_c4_reg;
    assign result.eighth_toggle      = out_eflag_reg;
    assign result.quarter_toggle     = out_qflag_reg;
    assign result.tempo_bpm          = out_tempo_reg;
    assign result.tempo_updated      = out_upd_reg;

endmodule
